/* hw/rtl/dftc_pkg.sv */
package dftc_pkg;

    localparam int TIMEOUT_TICKS_DEF = 100;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVF     = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    localparam logic [2:0] TYPE_ANALOG = 3'h3;
    localparam logic [3:0] GROUP_A     = 4'hA;
    localparam logic [3:0] GROUP_B     = 4'hB;

    localparam logic [2:0] REG_SLOT0 = 3'd0;
    localparam logic [2:0] REG_SLOT1 = 3'd1;
    localparam logic [2:0] REG_BACK  = 3'd2;
    localparam logic [2:0] REG_BLEV  = 3'd3;
    localparam logic [2:0] REG_FLEV  = 3'd4;
    localparam logic [2:0] REG_SCA   = 3'd5;
    localparam logic [2:0] REG_SCB   = 3'd6;
    localparam logic [2:0] REG_SCC   = 3'd7;

    typedef struct packed {
        logic        func;
        logic [10:0] can_id;
        logic [3:0]  frame_len;
        logic [63:0] payload;
    } in_req_t;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic signed [47:0] torque_x;
        logic signed [47:0] torque_y;
        logic signed [47:0] torque_z;
        logic [1:0]         status;
    } out_req_t;

    // Operation codes for the shared multiply-accumulate unit.
    typedef enum logic [1:0] {
        MAC_LOAD = 2'd0,
        MAC_ADD  = 2'd1,
        MAC_SUB  = 2'd2
    } mac_op_t;

    typedef struct packed {
        mac_op_t            op;
        logic signed [33:0] a;
        logic signed [33:0] b;
        logic               rnd;
    } mac_cmd_t;

endpackage

/* hw/rtl/dftc_mac.sv */
// Shared multiply-accumulate unit: one 34x34 signed product per cycle while
// en is high, optional Q16 rounding, accumulated into a 66-bit register.
module dftc_mac
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  dftc_pkg::mac_cmd_t cmd,
    output logic signed [65:0] acc
);
    import dftc_pkg::*;

    logic signed [67:0] prod;
    logic signed [65:0] term;
    logic signed [65:0] acc_reg;
    logic signed [65:0] acc_next;

    // Product, then optional round to nearest with ties going up.
    always_comb
    begin
        prod = 68'(cmd.a) * 68'(cmd.b);
        if (cmd.rnd)
        begin
            term = 66'((prod + 68'sd32768) >>> 16);
        end
        else
        begin
            term = prod[65:0];
        end
        case (cmd.op)
            MAC_LOAD: acc_next = term;
            MAC_ADD:  acc_next = acc_reg + term;
            MAC_SUB:  acc_next = acc_reg - term;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;
endmodule

/* hw/rtl/dual_ft_frame_decode_combine.sv */
// Dual force/torque frame decoder and wrench combiner.
// Input channel (in_valid/in_ready, in_data) carries CAN frames and timer
// ticks. Output channel (out_valid/out_ready, out_data) carries combined
// wrenches. Registers are written through the APB port at 8*index.
// An accepted frame that is not for this block, or a tick with no silent
// slot, finishes with no result. A matching frame of group A or B first
// decodes its samples, then combines them in sixteen multiply-accumulate
// steps plus one more for the last sum to settle; other updates only
// combine, in the same steps. Every product goes through the one shared
// multiply-accumulate unit, one operation per cycle while decoding or
// combining. The block takes one request at a time; in_ready is low
// while it works and while a result waits in the output register, so a
// stalled receiver holds the block until the result is taken.
// After reset the samples are zero, both slots read as timed out and the
// silence counters stand at the timeout limit plus one.
module dual_ft_frame_decode_combine
#(
    parameter int TIMEOUT_TICKS = dftc_pkg::TIMEOUT_TICKS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dftc_pkg::in_req_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dftc_pkg::out_req_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import dftc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_DEC   = 5'b00100,
        S_COMB  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    localparam logic [15:0] TLIM = 16'(TIMEOUT_TICKS);

    state_t state_reg, state_next;

    logic [3:0]  slot0_id_reg, slot1_id_reg;
    logic        back_reg;
    logic [31:0] blev_reg, flev_reg;
    logic [63:0] sca_reg, scb_reg, scc_reg;

    logic [31:0] samp_reg [12];
    logic [1:0]  sst_reg [2];
    logic [15:0] sil_reg [2];

    in_req_t     req_reg;
    logic        slot_reg;
    logic [3:0]  step_reg;
    out_req_t    out_reg;
    logic [1:0]  stat_sel;

    mac_cmd_t    cmd;
    logic signed [65:0] acc;
    logic        mac_en;

    // Configuration port.
    logic        wr;
    logic [2:0]  widx;
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_id_reg <= 4'd0;
            slot1_id_reg <= 4'd1;
            back_reg     <= 1'b0;
            blev_reg     <= '0;
            flev_reg     <= '0;
            sca_reg      <= '0;
            scb_reg      <= '0;
            scc_reg      <= '0;
        end
        else if (wr && paddr[2:0] == 3'd0)
        begin
            case (widx)
                REG_SLOT0: slot0_id_reg <= pwdata[3:0];
                REG_SLOT1: slot1_id_reg <= pwdata[3:0];
                REG_BACK:  back_reg     <= pwdata[0];
                REG_BLEV:  blev_reg     <= pwdata[31:0];
                REG_FLEV:  flev_reg     <= pwdata[31:0];
                REG_SCA:   sca_reg      <= pwdata;
                REG_SCB:   scb_reg      <= pwdata;
                REG_SCC:   scc_reg      <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_SLOT0: prdata = {60'd0, slot0_id_reg};
            REG_SLOT1: prdata = {60'd0, slot1_id_reg};
            REG_BACK:  prdata = {63'd0, back_reg};
            REG_BLEV:  prdata = {32'd0, blev_reg};
            REG_FLEV:  prdata = {32'd0, flev_reg};
            REG_SCA:   prdata = sca_reg;
            REG_SCB:   prdata = scb_reg;
            REG_SCC:   prdata = scc_reg;
            default:   prdata = '0;
        endcase
    end

    // Frame classification of the held request.
    logic       is_frame, hit0, hit1, match, grp_ab;
    logic [3:0] board, grp;
    logic [1:0] frame_st;
    assign board    = req_reg.can_id[7:4];
    assign grp      = req_reg.can_id[3:0];
    assign is_frame = !req_reg.func;
    assign hit0     = board == slot0_id_reg;
    assign hit1     = board == slot1_id_reg;
    assign match    = is_frame && req_reg.can_id[10:8] == TYPE_ANALOG && (hit0 || hit1);
    assign grp_ab   = grp == GROUP_A || grp == GROUP_B;

    always_comb
    begin
        if (req_reg.frame_len == 4'd6)
            frame_st = ST_OK;
        else if (req_reg.frame_len == 4'd7 && req_reg.payload[55:48] == 8'd1)
            frame_st = ST_OVF;
        else
            frame_st = ST_ERROR;
    end

    // Ticked counters and timeout flags.
    logic [15:0] sil_inc [2];
    logic [1:0]  tout;
    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            sil_inc[s] = (sil_reg[s] == 16'hFFFF) ? sil_reg[s] : sil_reg[s] + 16'd1;
            tout[s]    = sil_inc[s] > TLIM;
        end
    end

    // Decode step: sample index and full scale.
    logic [1:0]  k;
    logic [3:0]  sidx;
    logic [15:0] fscale;
    logic [15:0] word;
    logic [63:0] sword;
    assign k     = step_reg[1:0];
    assign sidx  = (slot_reg ? 4'd6 : 4'd0) + ((grp == GROUP_B) ? 4'd3 : 4'd0) + {2'd0, k};
    always_comb
    begin
        if (sidx < 4'd4)
            sword = sca_reg;
        else if (sidx < 4'd8)
            sword = scb_reg;
        else
            sword = scc_reg;
        fscale = sword[{sidx[1:0], 4'd0} +: 16];
        word   = req_reg.payload[{k, 4'd0} +: 16];
    end

    // Combine sequence: each step is one MAC operation on back/front samples.
    logic [3:0] bb, ff;
    assign bb = back_reg ? 4'd6 : 4'd0;
    assign ff = back_reg ? 4'd0 : 4'd6;

    function automatic logic signed [33:0] sx(input logic [31:0] v);
        sx = 34'(signed'(v));
    endfunction

    function automatic logic signed [47:0] sat(input logic signed [65:0] v);
        if (v > 66'sd140737488355327)
            sat = 48'sh7FFFFFFFFFFF;
        else if (v < -66'sd140737488355328)
            sat = 48'sh800000000000;
        else
            sat = v[47:0];
    endfunction

    // Sequence: steps 0..15 issue products; results stored after axis boundaries.
    always_comb
    begin
        cmd.op  = MAC_LOAD;
        cmd.a   = 34'sd1;
        cmd.b   = '0;
        cmd.rnd = 1'b0;
        mac_en  = 1'b0;
        if (state_reg == S_DEC)
        begin
            mac_en = 1'b1;
            cmd.a  = 34'({1'b0, word}) - 34'sd32768;
            cmd.b  = 34'({1'b0, fscale});
        end
        else if (state_reg == S_COMB)
        begin
            mac_en = 1'b1;
            case (step_reg)
                4'd0:  begin cmd.b = sx(samp_reg[bb + 4'd0]); end
                4'd1:  begin cmd.op = MAC_SUB; cmd.b = sx(samp_reg[ff + 4'd0]); end
                4'd2:  begin cmd.b = sx(samp_reg[bb + 4'd1]); end
                4'd3:  begin cmd.op = MAC_SUB; cmd.b = sx(samp_reg[ff + 4'd1]); end
                4'd4:  begin cmd.b = sx(samp_reg[bb + 4'd2]); end
                4'd5:  begin cmd.op = MAC_ADD; cmd.b = sx(samp_reg[ff + 4'd2]); end
                4'd6:  begin cmd.b = sx(samp_reg[bb + 4'd3]); end
                4'd7:  begin cmd.op = MAC_SUB; cmd.b = sx(samp_reg[ff + 4'd3]); end
                4'd8:  begin cmd.b = sx(samp_reg[bb + 4'd4]); end
                4'd9:  begin cmd.op = MAC_SUB; cmd.b = sx(samp_reg[ff + 4'd4]); end
                4'd10: begin cmd.op = MAC_ADD; cmd.rnd = 1'b1; cmd.a = sx(blev_reg);
                             cmd.b = sx(samp_reg[bb + 4'd2]); end
                4'd11: begin cmd.op = MAC_ADD; cmd.rnd = 1'b1; cmd.a = sx(flev_reg);
                             cmd.b = sx(samp_reg[ff + 4'd2]); end
                4'd12: begin cmd.b = sx(samp_reg[bb + 4'd5]); end
                4'd13: begin cmd.op = MAC_ADD; cmd.b = sx(samp_reg[ff + 4'd5]); end
                4'd14: begin cmd.op = MAC_SUB; cmd.rnd = 1'b1; cmd.a = sx(blev_reg);
                             cmd.b = sx(samp_reg[bb + 4'd1]); end
                default: begin cmd.op = MAC_ADD; cmd.rnd = 1'b1; cmd.a = sx(flev_reg);
                             cmd.b = sx(samp_reg[ff + 4'd1]); end
            endcase
        end
    end

    dftc_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (mac_en),
        .cmd   (cmd),
        .acc   (acc)
    );

    // Status priority across the two slots.
    always_comb
    begin
        if (sst_reg[0] == ST_ERROR || sst_reg[1] == ST_ERROR)
            stat_sel = ST_ERROR;
        else if (sst_reg[0] == ST_TIMEOUT || sst_reg[1] == ST_TIMEOUT)
            stat_sel = ST_TIMEOUT;
        else if (sst_reg[0] == ST_OVF || sst_reg[1] == ST_OVF)
            stat_sel = ST_OVF;
        else
            stat_sel = ST_OK;
    end

    // The last combine step's result lands in the accumulator in the cycle after issue.
    logic fin, fin_reg;
    assign fin = fin_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_EVAL;
            S_EVAL:
            begin
                if (match)
                    state_next = grp_ab ? S_DEC : S_COMB;
                else if (!is_frame && tout != 2'b00)
                    state_next = S_COMB;
                else
                    state_next = S_IDLE;
            end
            S_DEC:  if (step_reg == 4'd3) state_next = S_COMB;
            S_COMB: if (fin) state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            fin_reg   <= 1'b0;
            for (int i = 0; i < 12; i++) samp_reg[i] <= '0;
            for (int s = 0; s < 2; s++)
            begin
                sst_reg[s] <= ST_TIMEOUT;
                sil_reg[s] <= TLIM + 16'd1;
            end
            slot_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= 1'b0;
            case (state_reg)
                S_IDLE: step_reg <= '0;
                S_EVAL:
                begin
                    step_reg <= '0;
                    if (match)
                    begin
                        slot_reg <= hit1;
                        sil_reg[hit1] <= '0;
                        sst_reg[hit1] <= frame_st;
                    end
                    else if (!is_frame)
                    begin
                        for (int s = 0; s < 2; s++)
                        begin
                            sil_reg[s] <= sil_inc[s];
                            if (tout[s]) sst_reg[s] <= ST_TIMEOUT;
                        end
                    end
                end
                S_DEC:
                begin
                    // Store the previous product; k=0 issues the first.
                    if (step_reg != 4'd0)
                        samp_reg[sidx - 4'd1] <= acc[31:0];
                    step_reg <= (step_reg == 4'd3) ? 4'd0 : step_reg + 4'd1;
                end
                S_COMB:
                begin
                    if (!fin_reg)
                    begin
                        step_reg <= step_reg + 4'd1;
                        if (step_reg == 4'd15) fin_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Capture each axis when its last term has settled in the accumulator.
    logic [3:0] prev_reg;
    logic       comb_d_reg;
    always_ff @(posedge clk)
    begin
        prev_reg   <= step_reg;
        comb_d_reg <= state_reg == S_COMB && !fin_reg;
        req_reg    <= (state_reg == S_IDLE) ? in_data : req_reg;
        if (comb_d_reg)
        begin
            case (prev_reg)
                4'd1:  out_reg.force_x  <= sat(acc);
                4'd3:  out_reg.force_y  <= sat(acc);
                4'd5:  out_reg.force_z  <= sat(acc);
                4'd7:  out_reg.torque_x <= sat(acc);
                4'd11: out_reg.torque_y <= sat(acc);
                4'd15: out_reg.torque_z <= sat(acc);
                default: ;
            endcase
        end
        out_reg.status <= stat_sel;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_data  = out_reg;
endmodule

/* hw/rtl/dftc_checker.sv */
module dftc_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] status
);
    // The block never takes a request while a result waits.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("in_ready with pending result");

    // A result is never offered in the cycle after a request is taken.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");

    // A waiting result holds its status.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)))
        else $error("result dropped");
endmodule

bind dual_ft_frame_decode_combine dftc_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (out_data.status)
);
